// File: rtl/core/copy_text_byte_escaper_unit_assert.svh
// Assertion macros for the byte escaper unit.
// Used by the top level only; needs nothing else.
`ifndef COPY_TEXT_BYTE_ESCAPER_UNIT_ASSERT_SVH
`define COPY_TEXT_BYTE_ESCAPER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define CTE_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define CTE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/cte_pkg.sv
// Shared types, character constants and helper functions for the byte escaper.
// No dependencies; imported by every module of the unit.
package cte_pkg;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Widest escape is five characters
   localparam int IDX_W = 3;

   // ASCII characters used by the escapes
   localparam logic [7:0] CHAR_BSLASH  = 8'h5c;
   localparam logic [7:0] CHAR_QUOTE   = 8'h27;
   localparam logic [7:0] CHAR_NL      = 8'h0a;
   localparam logic [7:0] CHAR_CR      = 8'h0d;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_N = 8'h6e;
   localparam logic [7:0] CHAR_LOWER_R = 8'h72;
   localparam logic [7:0] CHAR_LOWER_T = 8'h74;
   localparam logic [7:0] CHAR_LOWER_X = 8'h78;
   localparam logic [7:0] PRINT_LOW    = 8'h20;
   localparam logic [7:0] PRINT_HIGH   = 8'h7e;

   // Escape mode register values
   localparam logic MODE_TEXT   = 1'b0;
   localparam logic MODE_BINARY = 1'b1;

   // Escape form chosen by the front
   typedef enum logic [1:0] {
      KIND_PASS  = 2'd0,   // byte as is
      KIND_TEXT2 = 2'd1,   // backslash plus letter
      KIND_HEX4  = 2'd2,   // backslash, x, two hex digits
      KIND_OCT5  = 2'd3    // two backslashes, three octal digits
   } kind_type;

   // One classified byte waiting to be expanded
   typedef struct packed {
      logic [7:0]       data_byte;
      logic             last_in;
      kind_type         kind;
      logic [IDX_W-1:0] final_idx;
   } desc_type;

   // Queue head as seen by the back
   typedef struct packed {
      logic     valid;
      desc_type data;
   } qhead_type;

   // Lowercase hex digit of a nibble
   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] wide;
      wide = {4'b0000, nib};
      if (nib < 4'd10) begin
         return CHAR_ZERO + wide;
      end else begin
         return CHAR_LOWER_A + wide - 8'd10;
      end
   endfunction

   // Octal digit of up to three bits
   function automatic logic [7:0] oct_char(input logic [2:0] digit);
      return CHAR_ZERO + {5'b00000, digit};
   endfunction

   // Letter that follows the backslash in a two-character text escape
   function automatic logic [7:0] text_letter(input logic [7:0] c);
      logic [7:0] res;
      case (c)
         CHAR_NL:  res = CHAR_LOWER_N;
         CHAR_CR:  res = CHAR_LOWER_R;
         CHAR_TAB: res = CHAR_LOWER_T;
         default:  res = CHAR_BSLASH;
      endcase
      return res;
   endfunction

   // Character at position idx of the escape of one descriptor
   function automatic logic [7:0] escape_char(input desc_type d,
                                              input logic [IDX_W-1:0] idx);
      logic [7:0] res;
      res = d.data_byte;
      case (d.kind)
         KIND_PASS: res = d.data_byte;
         KIND_TEXT2: begin
            res = (idx == '0) ? CHAR_BSLASH : text_letter(d.data_byte);
         end
         KIND_HEX4: begin
            case (idx)
               3'd0:    res = CHAR_BSLASH;
               3'd1:    res = CHAR_LOWER_X;
               3'd2:    res = hex_char(d.data_byte[7:4]);
               default: res = hex_char(d.data_byte[3:0]);
            endcase
         end
         KIND_OCT5: begin
            case (idx)
               3'd0, 3'd1: res = CHAR_BSLASH;
               3'd2:       res = oct_char({1'b0, d.data_byte[7:6]});
               3'd3:       res = oct_char(d.data_byte[5:3]);
               default:    res = oct_char(d.data_byte[2:0]);
            endcase
         end
         default: res = d.data_byte;
      endcase
      return res;
   endfunction

endpackage

// File: rtl/core/cte_front.sv
// Front of the byte escaper: holds the mode register, accepts input beats
// and classifies each byte into an escape form. Depends on cte_pkg.
module cte_front
   import cte_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     csr_wr_en,
   input  logic     csr_wr_data,
   input  logic     req_valid,
   output logic     req_stall,
   input  logic [7:0] req_data_byte,
   input  logic     req_last_in,
   input  logic     q_full,
   output logic     push,
   output desc_type push_data
);

   logic mode_ff;
   logic mode_in;
   logic printable;
   logic text_special;
   logic bin_escape;

   // Update the mode register on a write
   assign mode_in = csr_wr_en ? csr_wr_data : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_TEXT;
      end else begin
         mode_ff <= mode_in;
      end
   end

   // Stall while the queue has no room
   assign req_stall = q_full;
   assign push      = req_valid && !q_full;

   // Classify the byte
   assign printable    = (req_data_byte >= PRINT_LOW) && (req_data_byte <= PRINT_HIGH);
   assign text_special = (req_data_byte == CHAR_BSLASH) || (req_data_byte == CHAR_NL) ||
                         (req_data_byte == CHAR_CR) || (req_data_byte == CHAR_TAB);
   assign bin_escape   = !printable || (req_data_byte == CHAR_BSLASH) ||
                         (req_data_byte == CHAR_QUOTE);

   always_comb begin
      push_data.data_byte = req_data_byte;
      push_data.last_in   = req_last_in;
      push_data.kind      = KIND_PASS;
      push_data.final_idx = 3'd0;
      if (mode_ff == MODE_BINARY) begin
         if (bin_escape) begin
            push_data.kind      = KIND_OCT5;
            push_data.final_idx = 3'd4;
         end
      end else if (text_special) begin
         push_data.kind      = KIND_TEXT2;
         push_data.final_idx = 3'd1;
      end else if (!printable) begin
         push_data.kind      = KIND_HEX4;
         push_data.final_idx = 3'd3;
      end
   end

endmodule

// File: rtl/core/cte_queue.sv
// Short FIFO of classified bytes between front and back.
// Depends on cte_pkg for the descriptor type and depth.
module cte_queue
   import cte_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  desc_type  push_data,
   input  logic      pop,
   output logic      full,
   output qhead_type head
);

   desc_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff;
   logic [QCNT_W-1:0]   count_in;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.data  = entry_ff[rd_ptr_ff];

   // Advance pointers, wrapping at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed beat
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/core/cte_back.sv
// Back of the byte escaper: takes descriptors from the queue and plays out
// their escaped characters one beat at a time. Depends on cte_pkg.
module cte_back
   import cte_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  qhead_type  head,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_char,
   output logic       rsp_out_last,
   output logic       rsp_value_end
);

   desc_type         cur_ff;
   desc_type         cur_in;
   logic             cur_valid_ff;
   logic             cur_valid_in;
   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] idx_in;
   logic             at_final;
   logic             taken;
   logic             load;

   assign at_final = (idx_ff == cur_ff.final_idx);
   assign taken    = cur_valid_ff && !rsp_stall;

   // Load the next descriptor when empty or on the last character of this one
   assign load = !cur_valid_ff || (taken && at_final);
   assign pop  = load && head.valid;

   always_comb begin
      cur_valid_in = cur_valid_ff;
      cur_in       = cur_ff;
      idx_in       = idx_ff;
      if (load) begin
         cur_valid_in = head.valid;
         cur_in       = head.data;
         idx_in       = '0;
      end else if (taken) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   // Drive the result beat from the held descriptor and position
   assign rsp_valid     = cur_valid_ff;
   assign rsp_out_char  = escape_char(cur_ff, idx_ff);
   assign rsp_out_last  = at_final;
   assign rsp_value_end = at_final && cur_ff.last_in;

endmodule

// File: rtl/core/copy_text_byte_escaper_unit.sv
// Byte escaper for bulk-load text streams, top level.
// Input channel req_*: one raw byte (req_data_byte) and a last-of-value flag
// per beat, with req_valid / req_stall. Result channel rsp_*: one escaped
// character per beat, rsp_out_last on the final character of each byte,
// rsp_value_end on the final character of a byte that came with last set.
// csr_wr_en / csr_wr_data write the escape mode: 0 text escaping (one, two
// or four characters per byte), 1 binary octal escaping (one or five).
// A taken beat is written into the queue, then loaded into the back end's
// descriptor register, which drives its characters. The result side gives
// one character per cycle while the receiver does not stall; a byte has 1
// to 5 escaped characters, stepped by the back end's index. Plain bytes flow
// at one per cycle without stalls. A two-entry queue lets the input take a
// byte while a result beat is held; req_stall rises only when it is full.
// When the receiver stalls, the current character holds and the queue fills,
// then the input stalls. Reset clears the queue, the back end and the mode
// register (text mode); change the mode only while the unit is idle.
// Depends on cte_pkg, cte_front, cte_queue, cte_back and the assert header.
`include "copy_text_byte_escaper_unit_assert.svh"

module copy_text_byte_escaper_unit
   import cte_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_in,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_char,
   output logic       rsp_out_last,
   output logic       rsp_value_end
);

   logic      push;
   desc_type  push_data;
   logic      pop;
   logic      q_full;
   qhead_type head;

   // Accept and classify
   cte_front u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data_byte(req_data_byte),
      .req_last_in  (req_last_in),
      .q_full       (q_full),
      .push         (push),
      .push_data    (push_data)
   );

   // Decouple front from back
   cte_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(push_data),
      .pop      (pop),
      .full     (q_full),
      .head     (head)
   );

   // Expand into characters
   cte_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_char (rsp_out_char),
      .rsp_out_last (rsp_out_last),
      .rsp_value_end(rsp_value_end)
   );

   // Value end only on a byte's final character
   `CTE_ASSERT_NOW(a_end_is_last, clock, reset, rsp_valid && rsp_value_end, rsp_out_last, "value end without byte end")

   // A byte in mid escape keeps producing characters
   `CTE_ASSERT_NEXT(a_escape_continues, clock, reset, rsp_valid && !rsp_stall && !rsp_out_last, rsp_valid, "escape sequence broken")

   // A queued byte follows its predecessor without a gap
   `CTE_ASSERT_NEXT(a_no_bubble, clock, reset, rsp_valid && !rsp_stall && rsp_out_last && head.valid, rsp_valid, "bubble with queued byte")

endmodule
